### hw/rtl/etc1_block_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// ETC1 block decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef ETC1_BLOCK_DECODER_UNIT_MACROS_SVH
`define ETC1_BLOCK_DECODER_UNIT_MACROS_SVH

// plain property under clk, disabled while arst_n is low
`define ETC1_BD_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same-cycle implication
`define ETC1_BD_IMPLY(lbl, ante, cons, msg) \
	`ETC1_BD_CHECK(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define ETC1_BD_NEXT(lbl, ante, cons, msg) \
	`ETC1_BD_CHECK(lbl, (ante) |=> (cons), msg)

`endif

### hw/rtl/etc1_bd_pkg.sv
// ----------------------------------------------------------------------------
// ETC1 block decoder package
// Queue entry type, register indexes and the modifier table.
// ----------------------------------------------------------------------------
package etc1_bd_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned CFG_W       = 13;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [7:0] MOD_SMALL [8] = '{8'd2, 8'd5, 8'd9, 8'd13,
		8'd18, 8'd24, 8'd33, 8'd47};
	localparam logic [7:0] MOD_LARGE [8] = '{8'd8, 8'd17, 8'd29, 8'd42,
		8'd60, 8'd80, 8'd106, 8'd183};

	localparam logic [1:0] SEL_POS_SMALL = 2'd0;
	localparam logic [1:0] SEL_POS_LARGE = 2'd1;
	localparam logic [1:0] SEL_NEG_SMALL = 2'd2;
	localparam logic [1:0] SEL_NEG_LARGE = 2'd3;

	typedef logic [7:0] chan_t;

	typedef struct packed {
		chan_t [2:0] base0;
		chan_t [2:0] base1;
		logic  [2:0] tab0;
		logic  [2:0] tab1;
		logic        flip;
		logic [31:0] lo;
		logic        bad;
		logic [15:0] mask;
		logic  [9:0] bx;
		logic  [9:0] by;
	} etc1_bd_entry_t;

	function automatic logic signed [8:0] mod_value(input logic [2:0] tab,
		input logic [1:0] sel);
		logic [8:0] s;
		logic [8:0] l;
		logic signed [8:0] r;
		s = {1'b0, MOD_SMALL[tab]};
		l = {1'b0, MOD_LARGE[tab]};
		unique case (sel)
			SEL_POS_SMALL: r = $signed(s);
			SEL_POS_LARGE: r = $signed(l);
			SEL_NEG_SMALL: r = -$signed(s);
			SEL_NEG_LARGE: r = -$signed(l);
			default:       r = '0;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/etc1_bd_front.sv
// ----------------------------------------------------------------------------
// ETC1 block decoder front end
// Holds the image size registers, decodes base colours, tables and flip of
// an incoming block and marks which of its sixteen pixels lie in the image.
// ----------------------------------------------------------------------------
module etc1_bd_front #(
	parameter int unsigned MAX_DIM = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [12:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [63:0]                  block_word,
	input  logic [9:0]                   block_col,
	input  logic [9:0]                   block_row,
	input  logic                         q_full,
	output logic                         q_push,
	output etc1_bd_pkg::etc1_bd_entry_t  q_entry
);
	import etc1_bd_pkg::*;

	localparam int unsigned DIM_W     = $clog2(MAX_DIM + 1);
	localparam int unsigned CMP_W     = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam int unsigned RESET_DIM = (MAX_DIM > 8191) ? 8191 : MAX_DIM;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [31:0]      hi;
	logic             diff;
	logic [2:0]       bad_c;
	logic [3:0]       vx;
	logic [3:0]       vy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(RESET_DIM);
			height_q <= CFG_W'(RESET_DIM);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default:          width_q  <= width_q;
			endcase
		end
	end

	assign hi   = block_word[63:32];
	assign diff = hi[1];

	always_comb begin
		int msb;
		logic [3:0] nib0;
		logic [3:0] nib1;
		logic [4:0] b5;
		logic [2:0] d3;
		logic signed [6:0] sum;
		logic [4:0] d5;
		q_entry = '0;
		for (int c = 0; c < 3; c++) begin
			msb  = 31 - 8 * c;
			nib0 = hi[msb -: 4];
			nib1 = hi[msb - 4 -: 4];
			b5   = hi[msb -: 5];
			d3   = hi[msb - 5 -: 3];
			sum  = $signed({2'b00, b5}) + $signed({{4{d3[2]}}, d3});
			d5   = sum[4:0];
			bad_c[c] = (sum[6:5] != 2'b00);
			if (diff) begin
				q_entry.base0[c] = {b5, b5[4:2]};
				q_entry.base1[c] = {d5, d5[4:2]};
			end else begin
				q_entry.base0[c] = {nib0, nib0};
				q_entry.base1[c] = {nib1, nib1};
			end
		end
		for (int i = 0; i < 4; i++) begin
			vx[i] = (CMP_W'({block_col, 2'(i)}) < CMP_W'(width_q)) &&
				(CMP_W'({block_col, 2'(i)}) < CMP_W'(MAX_DIM));
			vy[i] = (CMP_W'({block_row, 2'(i)}) < CMP_W'(height_q)) &&
				(CMP_W'({block_row, 2'(i)}) < CMP_W'(MAX_DIM));
		end
		for (int x = 0; x < 4; x++) begin
			for (int y = 0; y < 4; y++) begin
				q_entry.mask[4 * x + y] = vx[x] & vy[y];
			end
		end
		q_entry.tab0 = hi[7:5];
		q_entry.tab1 = hi[4:2];
		q_entry.flip = hi[0];
		q_entry.lo   = block_word[31:0];
		q_entry.bad  = diff & (|bad_c);
		q_entry.bx   = block_col;
		q_entry.by   = block_row;
	end

	assign in_ready = ~q_full;
	assign q_push   = in_valid & ~q_full;

endmodule

### hw/rtl/etc1_bd_queue.sv
// ----------------------------------------------------------------------------
// ETC1 block decoder block queue
// Short first-in first-out buffer of decoded blocks between front and back.
// ----------------------------------------------------------------------------
`include "etc1_block_decoder_unit_macros.svh"

module etc1_bd_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  etc1_bd_pkg::etc1_bd_entry_t  push_entry,
	output logic                         full,
	input  logic                         pop,
	output logic                         head_valid,
	output etc1_bd_pkg::etc1_bd_entry_t  head
);
	import etc1_bd_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	etc1_bd_entry_t   slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`ETC1_BD_IMPLY(a_queue_no_overflow, push, !full || pop, "push into full queue")
	`ETC1_BD_IMPLY(a_queue_no_underflow, pop, head_valid, "pop from empty queue")
	`ETC1_BD_NEXT(a_queue_count_up, push && !pop, count_q == $past(count_q) + CNT_W'(1), "count did not grow")

endmodule

### hw/rtl/etc1_bd_back.sv
// ----------------------------------------------------------------------------
// ETC1 block decoder back end
// Walks the in-image pixels of the head block, one per cycle unless the output
// stalls, and forms the clamped colour of each into the output register.
// ----------------------------------------------------------------------------
`include "etc1_block_decoder_unit_macros.svh"

module etc1_bd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  etc1_bd_pkg::etc1_bd_entry_t  head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [11:0]                  pixel_x,
	output logic [11:0]                  pixel_y,
	output logic [7:0]                   red,
	output logic [7:0]                   green,
	output logic [7:0]                   blue,
	output logic                         bad_delta,
	output logic                         last
);
	import etc1_bd_pkg::*;

	logic [15:0] done_q;
	logic        out_valid_q;
	logic [15:0] rem;
	logic [15:0] pick;
	logic [3:0]  idx;
	logic        only;
	logic        load_en;
	logic        advance;
	logic        emit;
	logic        sub;
	logic [2:0]  tab;
	logic [1:0]  sel;
	logic signed [8:0] m;
	chan_t [2:0] base;
	chan_t [2:0] col;

	assign rem     = head.mask & ~done_q;
	assign pick    = rem & (~rem + 16'd1);
	assign only    = ((rem & (rem - 16'd1)) == 16'd0);
	assign load_en = ~out_valid_q | out_ready;
	assign advance = load_en & head_valid;
	assign emit    = advance & (rem != 16'd0);
	assign pop     = advance & ((rem == 16'd0) | only);

	always_comb begin
		idx = '0;
		for (int i = 0; i < 16; i++) begin
			if (pick[i]) begin
				idx = idx | 4'(i);
			end
		end
	end

	assign sub  = head.flip ? idx[1] : idx[3];
	assign tab  = sub ? head.tab1 : head.tab0;
	assign base = sub ? head.base1 : head.base0;
	assign sel  = {head.lo[{1'b1, idx}], head.lo[{1'b0, idx}]};
	assign m    = mod_value(tab, sel);

	always_comb begin
		logic signed [9:0] s;
		for (int c = 0; c < 3; c++) begin
			s = $signed({2'b00, base[c]}) + 10'(m);
			if (head.bad || s[9]) begin
				col[c] = 8'd0;
			end else if (s[8]) begin
				col[c] = 8'd255;
			end else begin
				col[c] = s[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				done_q <= '0;
			end else if (emit) begin
				done_q <= done_q | pick;
			end
			if (load_en) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x   <= {head.bx, idx[3:2]};
			pixel_y   <= {head.by, idx[1:0]};
			red       <= col[0];
			green     <= col[1];
			blue      <= col[2];
			bad_delta <= head.bad;
			last      <= only;
		end
	end

	assign out_valid = out_valid_q;

	`ETC1_BD_IMPLY(a_back_pick_onehot, emit, $onehot(pick), "pixel pick not one-hot")
	`ETC1_BD_IMPLY(a_back_done_in_mask, head_valid, (done_q & ~head.mask) == 16'd0, "done bit outside mask")
	`ETC1_BD_IMPLY(a_back_idle_clear, !head_valid, done_q == 16'd0, "done bits left without block")

endmodule

### hw/rtl/etc1_block_decoder_unit.sv
// ----------------------------------------------------------------------------
// ETC1 block decoder unit
// Decodes 64-bit ETC1 blocks into clamped RGB pixels, column-major order,
// skipping pixels outside the configured image size.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+-----------------------------
//   in      | input     | in_valid/in_ready  | block_word, block_col, row
//   out     | output    | out_valid/out_ready| one pixel with x, y, colour
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// A block yields up to sixteen pixel beats, one per cycle from the back
// end's pixel walker unless out_ready stalls it; the next queued block
// follows without a gap. A block with no in-image pixel yields no beat.
// The front accepts a new block whenever the two-entry queue has room.
// Reset sets both size registers to min(MAX_DIM, 8191) and empties the queue.
// ----------------------------------------------------------------------------
module etc1_block_decoder_unit #(
	parameter int unsigned MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] block_word,
	input  logic [9:0]  block_col,
	input  logic [9:0]  block_row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] pixel_x,
	output logic [11:0] pixel_y,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        bad_delta,
	output logic        last
);
	import etc1_bd_pkg::*;

	etc1_bd_entry_t q_entry;
	etc1_bd_entry_t head;
	logic           q_push;
	logic           q_full;
	logic           head_valid;
	logic           pop;

	etc1_bd_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.block_word (block_word),
		.block_col  (block_col),
		.block_row  (block_row),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_entry)
	);

	etc1_bd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	etc1_bd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.bad_delta  (bad_delta),
		.last       (last)
	);

endmodule
